// ===== rtl/core/scc_pkg.sv =====
// Shared types and constants for the Schur coloring checker.
package scc_pkg;

   localparam int NUMBER_W  = 9;
   localparam int COLOR_W   = 4;
   localparam int WITNESS_W = 8;
   localparam int FIRST_Z   = 3;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_TEST   = 2'd1;
   localparam logic [1:0] ACT_PREFIX = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic [NUMBER_W-1:0] number;
      logic [COLOR_W-1:0]  candidate_color;
   } req_type;

   typedef struct packed {
      logic                 sum_free;
      logic [WITNESS_W-1:0] witness_x;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ZREAD,
      ST_ZLOAD,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic mem_write;
      logic init_test;
      logic init_prefix;
      logic zread;
      logic zload;
      logic walk;
      logic next_z;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       test_ok;
      logic       write_ok;
      logic       prefix_short;
      logic       hit;
      logic       walk_done;
      logic       last_z;
      logic       out_free;
   } status_type;

endpackage

// ===== rtl/core/scc_datapath.sv =====
// Color memory, pair walk counters, compare stage and result register.
module scc_datapath #(
   parameter int MAX_NUMBER = 256,
   parameter int NUM_COLORS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scc_pkg::req_type     req_data,
   input  scc_pkg::cmd_type     cmd,
   output scc_pkg::status_type  status,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output scc_pkg::rsp_type     rsp_data
);

   localparam int AW  = $clog2(MAX_NUMBER);
   localparam int ZW0 = $clog2(MAX_NUMBER + 1);
   localparam int ZW  = (ZW0 > scc_pkg::NUMBER_W) ? ZW0 : scc_pkg::NUMBER_W;

   logic [scc_pkg::COLOR_W-1:0] color_mem [MAX_NUMBER];

   scc_pkg::req_type            req_ff, req_in;
   logic [ZW-1:0]               z_ff, z_in;
   logic [ZW-1:0]               x_ff, x_in;
   logic [ZW-1:0]               x_pipe_ff, x_pipe_in;
   logic                        pipe_ff, pipe_in;
   logic [ZW-1:0]               last_ff, last_in;
   logic [scc_pkg::COLOR_W-1:0] zc_ff, zc_in;
   logic [ZW-1:0]               witness_ff, witness_in;
   logic [scc_pkg::COLOR_W-1:0] rd_a_ff, rd_b_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   scc_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [ZW-1:0] number_ext;
   logic [ZW-1:0] number_m1;
   logic [ZW-1:0] last_calc;
   logic [ZW-1:0] half;
   logic [ZW-1:0] y_m1;
   logic [ZW-1:0] x_m1;
   logic [ZW-1:0] z_m1;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;
   logic [AW-1:0] addr_w;
   logic          issue;
   logic          hit;

   assign number_ext = ZW'(req_ff.number);
   assign number_m1  = (number_ext == '0) ? '0 : number_ext - ZW'(1);
   assign last_calc  = (number_m1 > ZW'(MAX_NUMBER)) ? ZW'(MAX_NUMBER) : number_m1;
   assign half       = z_ff >> 1;
   assign x_m1       = x_ff - ZW'(1);
   assign y_m1       = z_ff - x_ff - ZW'(1);
   assign z_m1       = z_ff - ZW'(1);
   assign addr_a     = cmd.zread ? z_m1[AW-1:0] : x_m1[AW-1:0];
   assign addr_b     = y_m1[AW-1:0];
   assign addr_w     = number_m1[AW-1:0];

   assign issue = cmd.walk && (x_ff <= half);
   assign hit   = pipe_ff && (rd_a_ff == zc_ff) && (rd_b_ff == zc_ff);

   always_comb begin
      status.action       = req_ff.action;
      status.test_ok      = (number_ext != '0) && (number_ext <= ZW'(MAX_NUMBER));
      status.write_ok     = status.test_ok
                            && (9'(req_ff.candidate_color) < 9'(NUM_COLORS));
      status.prefix_short = last_calc < ZW'(scc_pkg::FIRST_Z);
      status.hit          = hit;
      status.walk_done    = (x_ff > half) && !hit;
      status.last_z       = z_ff == last_ff;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      req_in       = req_ff;
      z_in         = z_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      zc_in        = zc_ff;
      witness_in   = witness_ff;
      pipe_in      = issue;
      x_pipe_in    = x_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.latch_req) begin
         req_in     = req_data;
         witness_in = '0;
      end
      if (cmd.init_test) begin
         z_in  = number_ext;
         zc_in = req_ff.candidate_color;
         x_in  = ZW'(1);
      end
      if (cmd.init_prefix) begin
         z_in    = ZW'(scc_pkg::FIRST_Z);
         last_in = last_calc;
      end
      if (cmd.zload) begin
         zc_in = rd_a_ff;
         x_in  = ZW'(1);
      end
      if (cmd.next_z) begin
         z_in = z_ff + ZW'(1);
      end
      if (issue) begin
         x_in = x_ff + ZW'(1);
      end
      if (hit) begin
         witness_in = x_pipe_ff;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.sum_free  = witness_ff == '0;
         rsp_data_in.witness_x = witness_ff[scc_pkg::WITNESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         color_mem[addr_w] <= req_ff.candidate_color;
      end
      rd_a_ff <= color_mem[addr_a];
      rd_b_ff <= color_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      z_ff        <= z_in;
      x_ff        <= x_in;
      x_pipe_ff   <= x_pipe_in;
      last_ff     <= last_in;
      zc_ff       <= zc_in;
      witness_ff  <= witness_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pipe_ff      <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/scc_controller.sv =====
// Sequencer for write, candidate test and prefix check items.
module scc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  scc_pkg::status_type  status,
   output scc_pkg::cmd_type     cmd
);

   scc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != scc_pkg::ST_IDLE;
      unique case (state_ff)
         scc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = scc_pkg::ST_DECODE;
            end
         end
         scc_pkg::ST_DECODE: begin
            state_in = scc_pkg::ST_FINISH;
            priority if (status.action == scc_pkg::ACT_WRITE) begin
               cmd.mem_write = status.write_ok;
            end else if (status.action == scc_pkg::ACT_TEST) begin
               if (status.test_ok) begin
                  cmd.init_test = 1'b1;
                  state_in      = scc_pkg::ST_WALK;
               end
            end else if (status.action == scc_pkg::ACT_PREFIX) begin
               if (!status.prefix_short) begin
                  cmd.init_prefix = 1'b1;
                  state_in        = scc_pkg::ST_ZREAD;
               end
            end else begin
               // unused action code: plain pass result
               state_in = scc_pkg::ST_FINISH;
            end
         end
         scc_pkg::ST_ZREAD: begin
            cmd.zread = 1'b1;
            state_in  = scc_pkg::ST_ZLOAD;
         end
         scc_pkg::ST_ZLOAD: begin
            cmd.zload = 1'b1;
            state_in  = scc_pkg::ST_WALK;
         end
         scc_pkg::ST_WALK: begin
            cmd.walk = !status.hit;
            priority if (status.hit) begin
               state_in = scc_pkg::ST_FINISH;
            end else if (status.walk_done) begin
               if (status.action == scc_pkg::ACT_PREFIX && !status.last_z) begin
                  cmd.next_z = 1'b1;
                  state_in   = scc_pkg::ST_ZREAD;
               end else begin
                  state_in = scc_pkg::ST_FINISH;
               end
            end else begin
               state_in = scc_pkg::ST_WALK;
            end
         end
         scc_pkg::ST_FINISH: begin
            // wait for room in the result register
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = scc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/schur_coloring_checker_unit.sv =====
// A write stores one color; a test of number z reads one color memory pair per
// cycle for x = 1..floor(z/2); a prefix check walks each z = 3..end-1 in turn,
// stopping at the first failing z. Items are handled one at a time; the next
// item is taken once the result is in the output register. Reset clears control
// state only; the color memory is not cleared and holds undefined colors until
// written.
module schur_coloring_checker_unit #(
   parameter int MAX_NUMBER = 256,
   parameter int NUM_COLORS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  scc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scc_pkg::rsp_type  rsp_data
);

   scc_pkg::cmd_type    cmd;
   scc_pkg::status_type status;

   scc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scc_datapath #(
      .MAX_NUMBER (MAX_NUMBER),
      .NUM_COLORS (NUM_COLORS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
